// ----- rtl/core/cma_pkg.sv -----
`default_nettype none

package cma_pkg;

    // default sizes for the top level parameters
    localparam int MAX_CLASSES_DEF = 16;
    localparam int COUNT_BITS_DEF  = 32;

    // fixed field widths
    localparam int LABEL_W     = 32;
    localparam int SLOT_W      = 4;
    localparam int OUT_CNT_W   = 32;
    localparam int CLASS_CNT_W = 5;

    localparam logic [CLASS_CNT_W-1:0] CLASS_CNT_RST = 5'd16;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_RECORD = 2'd1,
        OP_READ   = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    // label search status
    typedef struct packed {
        logic pred_hit;
        logic corr_hit;
    } match_t;

endpackage

`default_nettype wire

// ----- rtl/core/confusion_matrix_accumulator_core.sv -----
`default_nettype none

// channel   | direction | signals                                          | timing
// ----------+-----------+--------------------------------------------------+------------------------
// request   | in        | start, opcode, label_slot, label_value,          | taken when start && !busy
//           |           | predicted_label, correct_label, read_row,        |
//           |           | read_col; busy back                              |
// result    | out       | done, labels_equal, unknown_label, cell_count    | one cycle per done pulse
// config    | in        | cfg_we, cfg_wdata (class_count)                  | written when cfg_we high
//
// each request passes through three steps: accept, lookup plus count read, update plus
// write back; done pulses in the cycle after update, when busy is already low
// the count memory has separate read and write ports
// after reset a clearing pass zeroes the count memory, one cell a cycle,
// (1 << 2*clog2(MAX_CLASSES)) cells, 256 at the default size; busy is high then
// the receiver cannot stall, so no result is ever held back

module confusion_matrix_accumulator_core #(
    parameter int MAX_CLASSES = cma_pkg::MAX_CLASSES_DEF,
    parameter int COUNT_BITS  = cma_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request side
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        opcode,
    input  logic [cma_pkg::SLOT_W-1:0]        label_slot,
    input  logic signed [cma_pkg::LABEL_W-1:0] label_value,
    input  logic signed [cma_pkg::LABEL_W-1:0] predicted_label,
    input  logic signed [cma_pkg::LABEL_W-1:0] correct_label,
    input  logic [cma_pkg::SLOT_W-1:0]        read_row,
    input  logic [cma_pkg::SLOT_W-1:0]        read_col,
    // config
    input  logic                              cfg_we,
    input  logic [cma_pkg::CLASS_CNT_W-1:0]   cfg_wdata,
    // result side
    output logic                              done,
    output logic                              labels_equal,
    output logic                              unknown_label,
    output logic [cma_pkg::OUT_CNT_W-1:0]     cell_count
);

    localparam int IDX_W  = $clog2(MAX_CLASSES);
    localparam int ADDR_W = 2 * IDX_W;

    // control
    cma_pkg::state_t state_reg, state_next;
    logic            accept;
    logic            in_lookup;
    logic            in_update;
    logic            clearing;
    logic            clr_last;

    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [cma_pkg::CLASS_CNT_W-1:0] class_count_reg;

    // request held for the duration of the item
    logic [1:0]                  op_reg;
    logic [cma_pkg::SLOT_W-1:0]  slot_reg;
    logic [cma_pkg::LABEL_W-1:0] lval_reg;
    logic [cma_pkg::LABEL_W-1:0] pred_reg;
    logic [cma_pkg::LABEL_W-1:0] corr_reg;
    logic [cma_pkg::SLOT_W-1:0]  row_reg;
    logic [cma_pkg::SLOT_W-1:0]  col_reg;

    // lookup results
    cma_pkg::match_t   match;
    logic [IDX_W-1:0]  pred_idx;
    logic [IDX_W-1:0]  corr_idx;
    cma_pkg::match_t   match_reg;
    logic              eq_reg;
    logic              rd_ok_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              is_record;
    logic              is_read;
    logic              both_hit;
    logic              slot_ok;
    logic              rd_ok;

    // count memory
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [COUNT_BITS-1:0] cnt_inc;

    // result registers
    logic                          done_reg;
    logic                          labels_equal_reg;
    logic                          unknown_reg;
    logic [cma_pkg::OUT_CNT_W-1:0] cell_count_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cma_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = cma_pkg::ST_IDLE;
                end
            end
            cma_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = cma_pkg::ST_LOOKUP;
                end
            end
            cma_pkg::ST_LOOKUP:
            begin
                state_next = cma_pkg::ST_UPDATE;
            end
            cma_pkg::ST_UPDATE:
            begin
                state_next = cma_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cma_pkg::ST_IDLE;
            end
        endcase
    end

    // state decode
    always_comb
    begin
        busy      = 1'b1;
        in_lookup = 1'b0;
        in_update = 1'b0;
        clearing  = 1'b0;
        unique case (state_reg)
            cma_pkg::ST_CLEAR:  clearing  = 1'b1;
            cma_pkg::ST_IDLE:   busy      = 1'b0;
            cma_pkg::ST_LOOKUP: in_lookup = 1'b1;
            cma_pkg::ST_UPDATE: in_update = 1'b1;
            default:            busy      = 1'b1;
        endcase
    end

    assign accept   = start && !busy;
    assign clr_last = &clr_cnt_reg;
    assign clr_cnt_next = clearing ? clr_cnt_reg + ADDR_W'(1) : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= cma_pkg::ST_CLEAR;
            clr_cnt_reg     <= '0;
            class_count_reg <= cma_pkg::CLASS_CNT_RST;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= in_update;
            if (cfg_we)
            begin
                class_count_reg <= cfg_wdata;
            end
        end
    end

    // capture the request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            slot_reg <= label_slot;
            lval_reg <= label_value;
            pred_reg <= predicted_label;
            corr_reg <= correct_label;
            row_reg  <= read_row;
            col_reg  <= read_col;
        end
    end

    assign is_record = (op_reg == cma_pkg::OP_RECORD);
    assign is_read   = (op_reg == cma_pkg::OP_READ);
    // loads past the table and reads past the matrix are dropped
    assign slot_ok   = int'(slot_reg) < MAX_CLASSES;
    assign rd_ok     = (int'(row_reg) < MAX_CLASSES) && (int'(col_reg) < MAX_CLASSES);

    cma_label_table #(
        .MAX_CLASSES (MAX_CLASSES),
        .IDX_W       (IDX_W)
    ) u_label_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_en     (in_lookup && (op_reg == cma_pkg::OP_LOAD) && slot_ok),
        .load_slot   (IDX_W'(slot_reg)),
        .load_value  (lval_reg),
        .class_count (class_count_reg),
        .pred_label  (pred_reg),
        .corr_label  (corr_reg),
        .match       (match),
        .pred_idx    (pred_idx),
        .corr_idx    (corr_idx)
    );

    // cell address is {row, col}; record uses the search result
    assign ram_re    = in_lookup;
    assign ram_raddr = is_record ? {pred_idx, corr_idx}
                                 : {IDX_W'(row_reg), IDX_W'(col_reg)};

    always_ff @(posedge clk)
    begin
        if (in_lookup)
        begin
            match_reg <= match;
            eq_reg    <= (pred_reg == corr_reg);
            rd_ok_reg <= rd_ok;
            addr_reg  <= ram_raddr;
        end
    end

    assign both_hit = match_reg.pred_hit && match_reg.corr_hit;

    // saturating increment of the fetched cell
    assign cnt_inc = (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_BITS'(1);

    // one item in flight, so a write back always lands before the next read
    assign ram_we    = clearing || (in_update && is_record && both_hit);
    assign ram_waddr = clearing ? clr_cnt_reg : addr_reg;
    assign ram_wdata = clearing ? '0 : cnt_inc;

    cma_count_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (COUNT_BITS)
    ) u_count_ram (
        .clk   (clk),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata)
    );

    // result fields, valid with done
    always_ff @(posedge clk)
    begin
        if (in_update)
        begin
            labels_equal_reg <= is_record && eq_reg;
            unknown_reg      <= is_record && !both_hit;
            if (is_record && both_hit)
            begin
                cell_count_reg <= cma_pkg::OUT_CNT_W'(cnt_inc);
            end
            else if (is_read && rd_ok_reg)
            begin
                cell_count_reg <= cma_pkg::OUT_CNT_W'(ram_rdata);
            end
            else
            begin
                cell_count_reg <= '0;
            end
        end
    end

    assign done          = done_reg;
    assign labels_equal  = labels_equal_reg;
    assign unknown_label = unknown_reg;
    assign cell_count    = cell_count_reg;

    // a result only follows an update cycle
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == cma_pkg::ST_UPDATE))
        else $error("result strobe without update");

    // no request taken while the count memory is being cleared
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> busy)
        else $error("request accepted during clear");

    // an unknown label leaves no count in the result
    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && unknown_reg) |-> (cell_count_reg == '0))
        else $error("count reported with unknown label");

    // count writes outside the clear pass only come from records with both labels found
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && !clearing) |-> (in_update && is_record && both_hit))
        else $error("stray count write");

endmodule

`default_nettype wire

// ----- rtl/core/cma_label_table.sv -----
`default_nettype none

module cma_label_table #(
    parameter int MAX_CLASSES = cma_pkg::MAX_CLASSES_DEF,
    parameter int IDX_W       = $clog2(MAX_CLASSES)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load_en,
    input  logic [IDX_W-1:0]                  load_slot,
    input  logic [cma_pkg::LABEL_W-1:0]       load_value,
    input  logic [cma_pkg::CLASS_CNT_W-1:0]   class_count,
    input  logic [cma_pkg::LABEL_W-1:0]       pred_label,
    input  logic [cma_pkg::LABEL_W-1:0]       corr_label,
    output cma_pkg::match_t                   match,
    output logic [IDX_W-1:0]                  pred_idx,
    output logic [IDX_W-1:0]                  corr_idx
);

    logic [cma_pkg::LABEL_W-1:0] label_reg [MAX_CLASSES];
    logic [MAX_CLASSES-1:0]      loaded_reg;
    logic [MAX_CLASSES-1:0]      pred_vec;
    logic [MAX_CLASSES-1:0]      corr_vec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
        end
        else if (load_en)
        begin
            loaded_reg[load_slot] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            label_reg[load_slot] <= load_value;
        end
    end

    // one comparator pair per slot, only slots below class_count take part
    always_comb
    begin
        for (int i = 0; i < MAX_CLASSES; i++)
        begin
            pred_vec[i] = loaded_reg[i] && (i < int'(class_count))
                          && (label_reg[i] == pred_label);
            corr_vec[i] = loaded_reg[i] && (i < int'(class_count))
                          && (label_reg[i] == corr_label);
        end
    end

    // lowest matching slot wins
    always_comb
    begin
        pred_idx = '0;
        corr_idx = '0;
        for (int i = MAX_CLASSES - 1; i >= 0; i--)
        begin
            if (pred_vec[i])
            begin
                pred_idx = IDX_W'(i);
            end
            if (corr_vec[i])
            begin
                corr_idx = IDX_W'(i);
            end
        end
    end

    assign match.pred_hit = |pred_vec;
    assign match.corr_hit = |corr_vec;

endmodule

`default_nettype wire

// ----- rtl/core/cma_count_ram.sv -----
`default_nettype none

module cma_count_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = cma_pkg::COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

// confusion matrix accumulator: directed table followed by random phases, one class
// count per phase, every request predicted by a local matrix model and each done
// pulse checked against the oldest pending outcome
module testbench;

    import cma_pkg::*;

    // opcode 3 is not in the package enum, the block answers it with all zero
    localparam logic [1:0]  OP_UNUSED = 2'd3;

    localparam logic [31:0] LBL_MIN  = 32'h8000_0000;
    localparam logic [31:0] LBL_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] LBL_NEG1 = 32'hFFFF_FFFF;
    localparam logic [31:0] CNT_SAT  = 32'hFFFF_FFFF;

    localparam int NUM_PHASES      = 10;
    localparam int PHASE_REQUESTS  = 133;
    localparam int SETTLE_CYCLES   = 6;
    // covers the clearing pass after reset and the longest gap many times over
    localparam int STALL_LIMIT     = 4000;
    localparam int MAX_PRINTED     = 40;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  slot;
        logic [31:0] value;
        logic [31:0] pred;
        logic [31:0] corr;
        logic [3:0]  row;
        logic [3:0]  col;
    } request_t;

    typedef struct packed {
        logic        eq;
        logic        unk;
        logic [31:0] cnt;
    } outcome_t;

    typedef struct packed {
        request_t req;
        logic     typed;
        outcome_t want;
    } directed_row_t;

    // directed table, class count at its reset value of 16
    // rows with typed = 1 carry an outcome that is plain from the row itself,
    // the rest are left to the matrix model
    localparam int NUM_DIRECTED = 24;
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        // counts are zero right after the clearing pass, corners of the matrix
        '{'{OP_READ,   4'd0,  32'd0,    32'd0,    32'd0,    4'd0,  4'd0},  1'b1, '{1'b0, 1'b0, 32'd0}},
        '{'{OP_READ,   4'd0,  32'd0,    32'd0,    32'd0,    4'd15, 4'd15}, 1'b1, '{1'b0, 1'b0, 32'd0}},
        // empty table: unloaded slots match nothing, a zero label included
        '{'{OP_RECORD, 4'd0,  32'd0,    32'd0,    32'd0,    4'd0,  4'd0},  1'b1, '{1'b1, 1'b1, 32'd0}},
        '{'{OP_RECORD, 4'd0,  32'd0,    LBL_MIN,  LBL_MAX,  4'd0,  4'd0},  1'b1, '{1'b0, 1'b1, 32'd0}},
        // label loads at the extreme slots and values, result is all zero
        '{'{OP_LOAD,   4'd0,  LBL_MIN,  32'd0,    32'd0,    4'd0,  4'd0},  1'b1, '{1'b0, 1'b0, 32'd0}},
        '{'{OP_LOAD,   4'd15, LBL_MAX,  32'd0,    32'd0,    4'd0,  4'd0},  1'b1, '{1'b0, 1'b0, 32'd0}},
        '{'{OP_LOAD,   4'd1,  32'd0,    32'd0,    32'd0,    4'd0,  4'd0},  1'b1, '{1'b0, 1'b0, 32'd0}},
        '{'{OP_LOAD,   4'd2,  LBL_NEG1, 32'd0,    32'd0,    4'd0,  4'd0},  1'b1, '{1'b0, 1'b0, 32'd0}},
        // duplicate label in slot 3, slot 0 must win the search
        '{'{OP_LOAD,   4'd3,  LBL_MIN,  32'd0,    32'd0,    4'd0,  4'd0},  1'b1, '{1'b0, 1'b0, 32'd0}},
        // first hits: cell (0,15), then (1,1) twice
        '{'{OP_RECORD, 4'd0,  32'd0,    LBL_MIN,  LBL_MAX,  4'd0,  4'd0},  1'b1, '{1'b0, 1'b0, 32'd1}},
        '{'{OP_RECORD, 4'd0,  32'd0,    32'd0,    32'd0,    4'd0,  4'd0},  1'b1, '{1'b1, 1'b0, 32'd1}},
        '{'{OP_RECORD, 4'd0,  32'd0,    32'd0,    32'd0,    4'd0,  4'd0},  1'b1, '{1'b1, 1'b0, 32'd2}},
        '{'{OP_RECORD, 4'd0,  32'd0,    LBL_NEG1, LBL_MIN,  4'd0,  4'd0},  1'b0, '{1'b0, 1'b0, 32'd0}},
        // one side not in the table, nothing counted
        '{'{OP_RECORD, 4'd0,  32'd0,    32'd5,    32'd0,    4'd0,  4'd0},  1'b1, '{1'b0, 1'b1, 32'd0}},
        '{'{OP_READ,   4'd0,  32'd0,    32'd0,    32'd0,    4'd0,  4'd15}, 1'b1, '{1'b0, 1'b0, 32'd1}},
        '{'{OP_READ,   4'd0,  32'd0,    32'd0,    32'd0,    4'd15, 4'd0},  1'b1, '{1'b0, 1'b0, 32'd0}},
        '{'{OP_READ,   4'd0,  32'd0,    32'd0,    32'd0,    4'd2,  4'd0},  1'b0, '{1'b0, 1'b0, 32'd0}},
        // unused opcode with every field at ones
        '{'{OP_UNUSED, 4'd15, LBL_NEG1, LBL_NEG1, LBL_NEG1, 4'd15, 4'd15}, 1'b1, '{1'b0, 1'b0, 32'd0}},
        // overwrite slot 1, slots 1 and 2 now both hold -1
        '{'{OP_LOAD,   4'd1,  LBL_NEG1, 32'd0,    32'd0,    4'd0,  4'd0},  1'b1, '{1'b0, 1'b0, 32'd0}},
        '{'{OP_RECORD, 4'd0,  32'd0,    LBL_NEG1, LBL_NEG1, 4'd0,  4'd0},  1'b0, '{1'b0, 1'b0, 32'd0}},
        // zero was overwritten, so it is unknown now
        '{'{OP_RECORD, 4'd0,  32'd0,    32'd0,    LBL_MAX,  4'd0,  4'd0},  1'b1, '{1'b0, 1'b1, 32'd0}},
        '{'{OP_READ,   4'd0,  32'd0,    32'd0,    32'd0,    4'd1,  4'd1},  1'b0, '{1'b0, 1'b0, 32'd0}},
        '{'{OP_RECORD, 4'd0,  32'd0,    LBL_MAX,  LBL_MIN,  4'd0,  4'd0},  1'b0, '{1'b0, 1'b0, 32'd0}},
        '{'{OP_UNUSED, 4'd0,  32'd0,    32'd0,    32'd0,    4'd0,  4'd0},  1'b1, '{1'b0, 1'b0, 32'd0}}
    };

    // class count per random phase: extremes, zero and values above 16 among them
    int class_plan [NUM_PHASES] = '{1, 16, 0, 31, 8, 17, 2, 5, 12, 16};

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  opcode = OP_LOAD;
    logic [3:0]  label_slot = '0;
    logic [31:0] label_value = '0;
    logic [31:0] predicted_label = '0;
    logic [31:0] correct_label = '0;
    logic [3:0]  read_row = '0;
    logic [3:0]  read_col = '0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        done;
    logic        labels_equal;
    logic        unknown_label;
    logic [31:0] cell_count;

    // matrix model: label table, loaded flags, counts and the class count register
    logic [31:0] model_labels [16];
    logic        model_loaded [16];
    logic [31:0] model_counts [256];
    logic [4:0]  model_classes;

    // labels that records and loads draw from, so that lookups hit often
    logic [31:0] label_pool [8];

    outcome_t    pending_outcomes [$];
    int          mismatch_count = 0;
    int          stall_cycles = 0;

    confusion_matrix_accumulator_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .label_slot      (label_slot),
        .label_value     (label_value),
        .predicted_label (predicted_label),
        .correct_label   (correct_label),
        .read_row        (read_row),
        .read_col        (read_col),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .done            (done),
        .labels_equal    (labels_equal),
        .unknown_label   (unknown_label),
        .cell_count      (cell_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // number of table entries searched, class counts above 16 act as 16
    function automatic int active_classes();
        return (model_classes > 5'd16) ? 16 : int'(model_classes);
    endfunction

    // lowest loaded slot holding the label, 16 when there is none
    function automatic int locate_label(input logic [31:0] lbl);
        int n;
        n = active_classes();
        for (int i = 0; i < n; i++)
        begin
            if (model_loaded[i] && model_labels[i] == lbl)
                return i;
        end
        return 16;
    endfunction

    // applies one request to the matrix model and returns its outcome
    function automatic outcome_t tally_request(input request_t r);
        outcome_t o;
        int       pp;
        int       cp;
        int       cell_idx;
        o = '0;
        if (r.op == OP_LOAD)
        begin
            model_labels[r.slot] = r.value;
            model_loaded[r.slot] = 1'b1;
        end
        else if (r.op == OP_RECORD)
        begin
            pp = locate_label(r.pred);
            cp = locate_label(r.corr);
            o.eq = (r.pred == r.corr);
            if (pp >= 16 || cp >= 16)
                o.unk = 1'b1;
            else
            begin
                cell_idx = pp * 16 + cp;
                // count holds at its maximum
                if (model_counts[cell_idx] != CNT_SAT)
                    model_counts[cell_idx] = model_counts[cell_idx] + 32'd1;
                o.cnt = model_counts[cell_idx];
            end
        end
        else if (r.op == OP_READ)
            o.cnt = model_counts[int'(r.row) * 16 + int'(r.col)];
        return o;
    endfunction

    // mostly well formed traffic: loads into searched slots, records from the pool
    function automatic request_t random_request();
        request_t r;
        int       pick;
        int       n;
        r.op    = 2'($urandom_range(0, 3));
        r.slot  = 4'($urandom);
        r.value = $urandom;
        r.pred  = $urandom;
        r.corr  = $urandom;
        r.row   = 4'($urandom);
        r.col   = 4'($urandom);
        pick = $urandom_range(0, 99);
        n = active_classes();
        if (pick < 20)
        begin
            r.op = OP_LOAD;
            if (n > 0 && $urandom_range(0, 3) != 0)
                r.slot = 4'($urandom_range(0, n - 1));
            if ($urandom_range(0, 4) != 0)
                r.value = label_pool[$urandom_range(0, 7)];
        end
        else if (pick < 75)
        begin
            r.op = OP_RECORD;
            if ($urandom_range(0, 6) != 0)
                r.pred = label_pool[$urandom_range(0, 7)];
            if ($urandom_range(0, 6) != 0)
                r.corr = label_pool[$urandom_range(0, 7)];
        end
        else if (pick < 95)
            r.op = OP_READ;
        else
            r.op = OP_UNUSED;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t: %s is %0h, should be %0h", $realtime, what, got, want);
    endtask

    // drives one request, holds it until taken, then predicts its outcome
    task automatic issue_request(input request_t r, input logic typed, input outcome_t want);
        outcome_t predicted;
        start           <= 1'b1;
        opcode          <= r.op;
        label_slot      <= r.slot;
        label_value     <= r.value;
        predicted_label <= r.pred;
        correct_label   <= r.corr;
        read_row        <= r.row;
        read_col        <= r.col;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = tally_request(r);
        pending_outcomes.push_back(typed ? want : predicted);
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
    endtask

    // stop sending until every pending outcome has been seen, then let the block settle
    task automatic drain();
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_class_count(input logic [4:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_classes = value;
    endtask

    // result side: done is a one cycle strobe, checked at the edge that ends it
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_outcomes.size() == 0)
                report_mismatch("unexpected done, cell_count", cell_count, 32'd0);
            else
            begin
                want = pending_outcomes.pop_front();
                if (labels_equal !== want.eq)
                    report_mismatch("labels_equal", 32'(labels_equal), 32'(want.eq));
                if (unknown_label !== want.unk)
                    report_mismatch("unknown_label", 32'(unknown_label), 32'(want.unk));
                if (cell_count !== want.cnt)
                    report_mismatch("cell_count", cell_count, want.cnt);
            end
        end
    end

    // watchdog: cycles in which neither a request nor a result is taken
    always @(posedge clk)
    begin
        if (!rst_n || (start && busy === 1'b0) || done === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        bit quiet;
        for (int i = 0; i < 16; i++)
        begin
            model_labels[i] = '0;
            model_loaded[i] = 1'b0;
        end
        for (int i = 0; i < 256; i++)
            model_counts[i] = '0;
        model_classes = CLASS_CNT_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, the clearing pass simply holds off the first request
        foreach (directed_rows[i])
        begin
            if ($urandom_range(0, 3) == 0)
                idle_burst();
            issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // register written only with the block idle
            drain();
            write_class_count(5'(class_plan[ph]));
            label_pool[0] = 32'd0;
            label_pool[1] = LBL_NEG1;
            label_pool[2] = LBL_MIN;
            label_pool[3] = LBL_MAX;
            for (int k = 4; k < 8; k++)
                label_pool[k] = $urandom;
            // last phase runs back to back with no gaps
            quiet = (ph == NUM_PHASES - 1);
            for (int k = 0; k < PHASE_REQUESTS; k++)
            begin
                if (!quiet && $urandom_range(0, 4) == 0)
                    idle_burst();
                if (!quiet && $urandom_range(0, 79) == 0)
                    drain();
                issue_request(random_request(), 1'b0, '0);
            end
        end

        drain();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/cma_pkg.sv
rtl/core/cma_label_table.sv
rtl/core/cma_count_ram.sv
rtl/core/confusion_matrix_accumulator_core.sv
tb/sv/testbench.sv
